// File: rtl/bpc_pkg.sv
// Shared types and constants for the button press classifier.
package bpc_pkg;

  localparam int CFG_W  = 24;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 24'd5000;
  localparam logic [CFG_W-1:0] SHORT_RST    = 24'd100000;
  localparam logic [CFG_W-1:0] LONG_RST     = 24'd1000000;
  localparam logic [CFG_W-1:0] WINDOW_RST   = 24'd500000;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_SHORT    = 2'd1;
  localparam logic [1:0] REG_LONG     = 2'd2;
  localparam logic [1:0] REG_WINDOW   = 2'd3;

  localparam logic [1:0] KIND_SINGLE = 2'd0;
  localparam logic [1:0] KIND_DOUBLE = 2'd1;
  localparam logic [1:0] KIND_LONG   = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] short_min_time;
    logic [CFG_W-1:0] long_min_time;
    logic [CFG_W-1:0] double_window;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
  } result_t;

endpackage

// File: rtl/bpc_sample_if.sv
// Sample channel: raw button level and timestamp.
interface bpc_sample_if #(
  parameter int TIME_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic                 raw_pressed;
  logic [TIME_BITS-1:0] now_time;

  modport source (output valid, output raw_pressed, output now_time, input ready);
  modport sink (input valid, input raw_pressed, input now_time, output ready);
endinterface

// File: rtl/bpc_result_if.sv
// Result channel: classified press kind.
interface bpc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] press_kind;

  modport source (output valid, output press_kind, input ready);
  modport sink (input valid, input press_kind, output ready);
endinterface

// File: rtl/bpc_cfg.sv
// APB configuration registers for the classifier thresholds.
module bpc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [bpc_pkg::DATA_W-1:0]   pwdata,
  output logic [bpc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output bpc_pkg::cfg_t                cfg
);

  logic [1:0]                idx;
  logic                      wr;
  logic [bpc_pkg::CFG_W-1:0] wval;
  logic [bpc_pkg::CFG_W-1:0] rval;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign wval   = pwdata[bpc_pkg::CFG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_time  <= bpc_pkg::DEBOUNCE_RST;
      cfg.short_min_time <= bpc_pkg::SHORT_RST;
      cfg.long_min_time  <= bpc_pkg::LONG_RST;
      cfg.double_window  <= bpc_pkg::WINDOW_RST;
    end else if (wr) begin
      unique case (idx)
        bpc_pkg::REG_DEBOUNCE: cfg.debounce_time  <= wval;
        bpc_pkg::REG_SHORT:    cfg.short_min_time <= wval;
        bpc_pkg::REG_LONG:     cfg.long_min_time  <= wval;
        bpc_pkg::REG_WINDOW:   cfg.double_window  <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bpc_pkg::REG_DEBOUNCE: rval = cfg.debounce_time;
      bpc_pkg::REG_SHORT:    rval = cfg.short_min_time;
      bpc_pkg::REG_LONG:     rval = cfg.long_min_time;
      bpc_pkg::REG_WINDOW:   rval = cfg.double_window;
      default:               rval = '0;
    endcase
  end

  assign prdata = {{(bpc_pkg::DATA_W - bpc_pkg::CFG_W){1'b0}}, rval};

endmodule

// File: rtl/bpc_core.sv
// Debounce and press classification state with its single-pass next-state logic.
module bpc_core #(
  parameter int TIME_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 level,
  input  logic [TIME_BITS-1:0] now,
  input  bpc_pkg::cfg_t        cfg,
  output bpc_pkg::result_t     res
);

  localparam int PAD = TIME_BITS - bpc_pkg::CFG_W;

  logic                 stable_level, stable_level_next;
  logic [TIME_BITS-1:0] edge_time, edge_time_next;
  logic [TIME_BITS-1:0] press_begin, press_begin_next;
  logic [TIME_BITS-1:0] release_time, release_time_next;
  logic                 tap_pending, tap_pending_next;

  logic [TIME_BITS-1:0] el_edge, el_press, el_rel;
  logic [TIME_BITS-1:0] debounce_x, short_x, long_x, window_x;
  logic                 change;

  assign el_edge  = now - edge_time;
  assign el_press = now - press_begin;
  assign el_rel   = now - release_time;

  assign debounce_x = {{PAD{1'b0}}, cfg.debounce_time};
  assign short_x    = {{PAD{1'b0}}, cfg.short_min_time};
  assign long_x     = {{PAD{1'b0}}, cfg.long_min_time};
  assign window_x   = {{PAD{1'b0}}, cfg.double_window};

  assign change = (level != stable_level) && (el_edge >= debounce_x);

  always_comb begin
    stable_level_next = stable_level;
    edge_time_next    = edge_time;
    press_begin_next  = press_begin;
    release_time_next = release_time;
    tap_pending_next  = tap_pending;
    res.valid         = 1'b0;
    res.kind          = bpc_pkg::KIND_SINGLE;

    if (change) begin
      stable_level_next = level;
      edge_time_next    = now;
      if (level) begin
        press_begin_next = now;
      end else if (el_press >= long_x) begin
        res.valid        = 1'b1;
        res.kind         = bpc_pkg::KIND_LONG;
        tap_pending_next = 1'b0;
      end else if (el_press >= short_x) begin
        if (!tap_pending) begin
          tap_pending_next  = 1'b1;
          release_time_next = now;
        end else if (el_rel <= window_x) begin
          res.valid        = 1'b1;
          res.kind         = bpc_pkg::KIND_DOUBLE;
          tap_pending_next = 1'b0;
        end else begin
          res.valid         = 1'b1;
          res.kind          = bpc_pkg::KIND_SINGLE;
          release_time_next = now;
        end
      end
    end

    // window expiry; a tap opened by this sample cannot expire yet
    if (!res.valid && tap_pending && tap_pending_next && (el_rel > window_x)) begin
      res.valid        = 1'b1;
      res.kind         = bpc_pkg::KIND_SINGLE;
      tap_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level <= 1'b0;
      edge_time    <= '0;
      press_begin  <= '0;
      release_time <= '0;
      tap_pending  <= 1'b0;
    end else if (step) begin
      stable_level <= stable_level_next;
      edge_time    <= edge_time_next;
      press_begin  <= press_begin_next;
      release_time <= release_time_next;
      tap_pending  <= tap_pending_next;
    end
  end

endmodule

// File: rtl/button_press_classifier.sv
// Top level of the button press classifier.
// Usage:
//   sample: one word per tick with raw_pressed and a wrapping now_time stamp.
//   result: one word per detected gesture, press_kind 0 single, 1 double,
//           2 long; most samples give no word.
//   APB:    four 24-bit thresholds at byte addresses 0, 4, 8, 12, written
//           while the block is idle; reads return the stored values.
// Path: an accepted sample goes into the input register, then the classify
//   step writes its word into the result register.
// Throughput: one sample per cycle while the result side does not stall; the
//   classify step is combinational between the input and result registers.
// Stall: the input register holds its sample while the result register is
//   full and not taken; sample.ready drops only in that case, so one more
//   word can be taken while a result waits.
// Reset: rst clears the gesture state, both registers' valid flags and
//   reloads the thresholds with their defaults.
module button_press_classifier #(
  parameter int TIME_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  bpc_sample_if.sink                        sample,
  bpc_result_if.source                      result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]        paddr,
  input  logic [bpc_pkg::DATA_W-1:0]        pwdata,
  output logic [bpc_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  bpc_pkg::cfg_t        cfg;
  bpc_pkg::result_t     res;
  logic                 ivalid;
  logic                 ilevel;
  logic [TIME_BITS-1:0] inow;
  logic                 ovalid;
  logic [1:0]           okind;
  logic                 advance;
  logic                 accept;

  assign advance      = ivalid && (!ovalid || result.ready);
  assign sample.ready = !ivalid || advance;
  assign accept       = sample.valid && sample.ready;

  assign result.valid      = ovalid;
  assign result.press_kind = okind;

  bpc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .level (ilevel),
    .now   (inow),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (accept) begin
      ivalid <= 1'b1;
    end else if (advance) begin
      ivalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ilevel <= sample.raw_pressed;
      inow   <= sample.now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (advance) begin
      ovalid <= res.valid;
    end else if (result.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      okind <= res.kind;
    end
  end

endmodule

// File: rtl/bpc_checker.sv
// Port-level assertions for the button press classifier, with bind.
module bpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] press_kind
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(press_kind))
    else $error("result word dropped or changed while stalled");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (press_kind == bpc_pkg::KIND_SINGLE ||
                   press_kind == bpc_pkg::KIND_DOUBLE ||
                   press_kind == bpc_pkg::KIND_LONG))
    else $error("press_kind holds an unused code");

  a_ready_pass: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("sample side stalled while result side drains");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (sample.valid),
  .in_ready   (sample.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .press_kind (result.press_kind)
);

// File: sim/tb_button_press_classifier.sv
// Testbench for button_press_classifier: predicts the press words from the samples and checks them.
module tb_button_press_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TB_TIME_BITS = 48;
  localparam int TB_CFG_W     = bpc_pkg::CFG_W;
  localparam int TB_ADDR_W    = bpc_pkg::ADDR_W;
  localparam int TB_DATA_W    = bpc_pkg::DATA_W;
  localparam int IDLE_PCT     = 28;
  localparam int HOLD_CYCLES  = 160;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_SHOWN    = 40;
  localparam int SETTLE       = 6;
  localparam logic [TB_CFG_W-1:0] CFG_MAX = {TB_CFG_W{1'b1}};

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [TB_ADDR_W-1:0] paddr;
  logic [TB_DATA_W-1:0] pwdata;
  logic [TB_DATA_W-1:0] prdata;
  logic                 pready;

  bpc_sample_if #(.TIME_BITS(TB_TIME_BITS)) smp ();
  bpc_result_if res ();

  button_press_classifier #(.TIME_BITS(TB_TIME_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .sample(smp),
    .result(res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // classifier state as the block should hold it
  bpc_pkg::cfg_t           thr = {bpc_pkg::DEBOUNCE_RST, bpc_pkg::SHORT_RST,
                                  bpc_pkg::LONG_RST, bpc_pkg::WINDOW_RST};
  logic                    lvl_settled = 1'b0;
  logic [TB_TIME_BITS-1:0] last_change = '0;
  logic [TB_TIME_BITS-1:0] press_start = '0;
  logic [TB_TIME_BITS-1:0] tap_release = '0;
  logic                    tap_waiting = 1'b0;

  logic [1:0]              gestures_due[$];
  int                      mismatches = 0;
  int                      cycles = 0;
  int                      sent_count = 0;
  logic [TB_TIME_BITS-1:0] t_stamp = '0;
  logic                    last_raw = 1'b0;
  bit                      send_steady = 1'b0;
  bit                      recv_steady = 1'b0;
  int                      hold_seq = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [TB_TIME_BITS-1:0] since(input logic [TB_TIME_BITS-1:0] later,
                                                     input logic [TB_TIME_BITS-1:0] earlier);
    return later - earlier;
  endfunction

  function automatic void classify_sample(input logic lvl, input logic [TB_TIME_BITS-1:0] now,
                                          output logic hit, output logic [1:0] kind);
    logic [TB_TIME_BITS-1:0] held;
    hit = 1'b0;
    kind = bpc_pkg::KIND_SINGLE;
    if (lvl != lvl_settled && since(now, last_change) >= thr.debounce_time) begin
      lvl_settled = lvl;
      last_change = now;
      if (lvl) begin
        press_start = now;
      end else begin
        held = since(now, press_start);
        if (held >= thr.long_min_time) begin
          hit = 1'b1;
          kind = bpc_pkg::KIND_LONG;
          tap_waiting = 1'b0;
        end else if (held >= thr.short_min_time) begin
          if (!tap_waiting) begin
            tap_waiting = 1'b1;
            tap_release = now;
          end else if (since(now, tap_release) <= thr.double_window) begin
            hit = 1'b1;
            kind = bpc_pkg::KIND_DOUBLE;
            tap_waiting = 1'b0;
          end else begin
            // late second tap: flush the old one, new tap opens its own window
            hit = 1'b1;
            kind = bpc_pkg::KIND_SINGLE;
            tap_release = now;
          end
        end
      end
    end
    if (!hit && tap_waiting && since(now, tap_release) > thr.double_window) begin
      hit = 1'b1;
      kind = bpc_pkg::KIND_SINGLE;
      tap_waiting = 1'b0;
    end
  endfunction

  function automatic logic [TB_CFG_W-1:0] thr_value(input logic [1:0] idx);
    case (idx)
      bpc_pkg::REG_DEBOUNCE: return thr.debounce_time;
      bpc_pkg::REG_SHORT:    return thr.short_min_time;
      bpc_pkg::REG_LONG:     return thr.long_min_time;
      default:               return thr.double_window;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_SHOWN) $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : port_watch
    logic [1:0] want;
    logic       hit;
    logic [1:0] kind;
    if (!rst) begin
      if (res.valid && res.ready) begin
        if (gestures_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word, press_kind %0d", res.press_kind));
        end else begin
          want = gestures_due.pop_front();
          if (res.press_kind !== want)
            report_mismatch($sformatf("press_kind %0d, want %0d", res.press_kind, want));
        end
      end
      if (smp.valid && smp.ready) begin
        classify_sample(smp.raw_pressed, smp.now_time, hit, kind);
        if (hit) gestures_due.push_back(kind);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= recv_steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic offer_sample(input logic lvl, input logic [TB_TIME_BITS-1:0] stamp);
    while (!send_steady && $urandom_range(0, 99) < IDLE_PCT) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.raw_pressed <= lvl;
    smp.now_time <= stamp;
    last_raw = lvl;
    sent_count++;
    do @(posedge clk); while (!smp.ready);
  endtask

  task automatic wait_all_words();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (gestures_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [TB_CFG_W-1:0] value);
    logic [TB_DATA_W-TB_CFG_W-1:0] junk;
    junk = (TB_DATA_W-TB_CFG_W)'($urandom);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {junk, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      bpc_pkg::REG_DEBOUNCE: thr.debounce_time = value;
      bpc_pkg::REG_SHORT:    thr.short_min_time = value;
      bpc_pkg::REG_LONG:     thr.long_min_time = value;
      default:               thr.double_window = value;
    endcase
    @(posedge clk);
  endtask

  task automatic reg_check(input logic [1:0] idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== TB_DATA_W'(thr_value(idx)))
      report_mismatch($sformatf("register %0d reads %0h, want %0h", idx, prdata, thr_value(idx)));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_all_registers();
    reg_check(bpc_pkg::REG_DEBOUNCE);
    reg_check(bpc_pkg::REG_SHORT);
    reg_check(bpc_pkg::REG_LONG);
    reg_check(bpc_pkg::REG_WINDOW);
  endtask

  task automatic apply_thresholds(input logic [TB_CFG_W-1:0] deb, input logic [TB_CFG_W-1:0] sh,
                                  input logic [TB_CFG_W-1:0] lg, input logic [TB_CFG_W-1:0] win);
    wait_all_words();
    reg_write(bpc_pkg::REG_DEBOUNCE, deb);
    reg_write(bpc_pkg::REG_SHORT, sh);
    reg_write(bpc_pkg::REG_LONG, lg);
    reg_write(bpc_pkg::REG_WINDOW, win);
    check_all_registers();
  endtask

  function automatic int unsigned span(input int unsigned lo, input int unsigned hi);
    if (hi <= lo) return lo;
    return $urandom_range(hi, lo);
  endfunction

  function automatic int unsigned pick_hold();
    int unsigned db;
    int unsigned sh;
    int unsigned lg;
    db = 32'(thr.debounce_time);
    sh = 32'(thr.short_min_time);
    lg = 32'(thr.long_min_time);
    case ($urandom_range(0, 9))
      0, 1:       return span(0, sh);
      2, 3, 4, 5: return span(sh, lg);
      6, 7:       return span(lg, lg + lg / 2 + 1);
      default: begin
        case ($urandom_range(0, 5))
          0:       return (db > 0) ? db - 1 : 0;
          1:       return db;
          2:       return (sh > 0) ? sh - 1 : 0;
          3:       return sh;
          4:       return (lg > 0) ? lg - 1 : 0;
          default: return lg;
        endcase
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned db;
    int unsigned win;
    db = 32'(thr.debounce_time);
    win = 32'(thr.double_window);
    case ($urandom_range(0, 9))
      0:          return span(0, db);
      1, 2, 3, 4: return span(db, db + win / 2);
      5:          return win;
      6:          return win + 1;
      default:    return span(win, 2 * win + db + 1);
    endcase
  endfunction

  // mostly clean presses and tap pairs; some chatter, jumps and backward stamps
  task automatic random_gestures(input int n);
    int          stop_at;
    int unsigned db;
    int unsigned sh;
    int unsigned win;
    int          roll;
    stop_at = sent_count + n;
    while (sent_count < stop_at) begin
      db = 32'(thr.debounce_time);
      sh = 32'(thr.short_min_time);
      win = 32'(thr.double_window);
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        t_stamp += TB_TIME_BITS'(pick_gap());
        offer_sample(1'b1, t_stamp);
        t_stamp += TB_TIME_BITS'(pick_hold());
        offer_sample(1'b0, t_stamp);
      end else if (roll < 70) begin
        repeat (2) begin
          t_stamp += TB_TIME_BITS'(span(db, db + win / 4));
          offer_sample(1'b1, t_stamp);
          t_stamp += TB_TIME_BITS'(span(sh, sh + win / 3));
          offer_sample(1'b0, t_stamp);
        end
      end else if (roll < 80) begin
        t_stamp += TB_TIME_BITS'(pick_gap());
        offer_sample(last_raw, t_stamp);
      end else if (roll < 88) begin
        repeat (span(2, 4)) begin
          t_stamp += TB_TIME_BITS'(span(0, db));
          offer_sample(!last_raw, t_stamp);
        end
      end else if (roll < 95) begin
        t_stamp = TB_TIME_BITS'({$urandom, $urandom});
        offer_sample(1'($urandom_range(0, 1)), t_stamp);
      end else begin
        t_stamp -= TB_TIME_BITS'(span(1, db + 1));
        offer_sample(1'($urandom_range(0, 1)), t_stamp);
      end
    end
  endtask

  task automatic test_register_defaults();
    check_all_registers();
  endtask

  task automatic test_directed_gestures();
    offer_sample(1'b0, 48'd0);
    offer_sample(1'b1, 48'd2000);        // bounce, too soon after last edge
    offer_sample(1'b1, 48'd10000);
    offer_sample(1'b0, 48'd12000);       // bounce on release
    offer_sample(1'b0, 48'd210000);      // tap waits
    offer_sample(1'b0, 48'd710000);      // window just reached, still waiting
    offer_sample(1'b0, 48'd710001);      // window expired: single
    offer_sample(1'b1, 48'd800000);
    offer_sample(1'b0, 48'd950000);
    offer_sample(1'b1, 48'd1000000);
    offer_sample(1'b0, 48'd1150000);     // double
    offer_sample(1'b1, 48'd1200000);
    offer_sample(1'b0, 48'd2200000);     // long at exact threshold
    offer_sample(1'b1, 48'd2300000);
    offer_sample(1'b0, 48'd2400000);     // tap at exact short threshold
    offer_sample(1'b1, 48'd2410000);
    offer_sample(1'b0, 48'd2420000);     // too brief, waiting tap untouched
    offer_sample(1'b1, 48'd2800000);
    offer_sample(1'b0, 48'd3000000);     // late second tap: single, new window
    offer_sample(1'b1, 48'd3400000);
    offer_sample(1'b0, 48'd4600000);     // long drops the waiting tap
    offer_sample(1'b0, 48'd5200000);
    offer_sample(1'b1, 48'hFFFF_FFFF_FF00);
    offer_sample(1'b0, 48'd199744);      // tap across the wrap
    offer_sample(1'b0, 48'hFFFF_FFFF_FFFF); // stamp runs back: huge elapsed
    offer_sample(1'b1, 48'd0);
    t_stamp = '0;
    wait_all_words();
  endtask

  task automatic test_default_random();
    random_gestures(250);
    wait_all_words();
  endtask

  task automatic test_steady_stream();
    send_steady = 1'b1;
    recv_steady <= 1'b1;
    random_gestures(120);
    send_steady = 1'b0;
    recv_steady <= 1'b0;
    wait_all_words();
  endtask

  task automatic test_result_backpressure();
    send_steady = 1'b1;
    hold_seq <= hold_seq + 1;
    repeat (12) begin
      t_stamp += TB_TIME_BITS'(thr.debounce_time) + 1;
      offer_sample(1'b1, t_stamp);
      t_stamp += TB_TIME_BITS'(thr.long_min_time) + TB_TIME_BITS'(thr.debounce_time) + 1;
      offer_sample(1'b0, t_stamp);
    end
    send_steady = 1'b0;
    wait_all_words();
  endtask

  task automatic test_threshold_sweep();
    apply_thresholds('0, '0, '0, '0);
    random_gestures(80);
    apply_thresholds(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
    random_gestures(80);
    // short above long: long wins
    apply_thresholds(24'd50, 24'd800, 24'd300, 24'd1000);
    random_gestures(80);
    apply_thresholds(24'd20, 24'd100, 24'd1000, 24'd500);
    random_gestures(80);
    apply_thresholds(TB_CFG_W'(span(0, 3000)), TB_CFG_W'(span(0, 20000)),
                     TB_CFG_W'(span(0, 60000)), TB_CFG_W'(span(0, 40000)));
    random_gestures(80);
    apply_thresholds(24'd0, 24'd5000, CFG_MAX, 24'd0);
    random_gestures(60);
    wait_all_words();
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    smp.valid <= 1'b0;
    smp.raw_pressed <= 1'b0;
    smp.now_time <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_defaults();
    test_directed_gestures();
    test_default_random();
    test_steady_stream();
    test_result_backpressure();
    test_threshold_sweep();

    wait_all_words();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
